### rtl/core/mtsoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsoc_pkg: shared types, constants and functions of the seed offset check.
// Holds the generator constants, the per-item sideband and the twist and
// temper functions.
// ----------------------------------------------------------------------------
package mtsoc_pkg;

  localparam logic [31:0] InitMult  = 32'h6c07_8965;
  localparam logic [31:0] TwistXor  = 32'h9908_b0df;
  localparam logic [31:0] HighBit   = 32'h8000_0000;
  localparam logic [31:0] LowBits   = 32'h7fff_ffff;
  localparam logic [31:0] TemperB   = 32'h9d2c_5680;
  localparam logic [31:0] TemperC   = 32'hefc6_0000;
  localparam int unsigned ShiftM    = 397;
  localparam int unsigned InitLen   = ShiftM + 3;
  localparam int unsigned LoWords   = 5;
  localparam int unsigned HiWords   = 4;
  localparam int unsigned RemSteps  = 32;

  // Targets, range and mode that travel with an item.
  typedef struct packed {
    logic [15:0] tx;
    logic [15:0] tz;
    logic [15:0] m;
    logic        tri_mode;
  } side_t;

  // Everything an init stage carries besides the running word.
  typedef struct packed {
    logic [LoWords-1:0][31:0] lo;
    logic [HiWords-1:0][31:0] hi;
    side_t                    side;
  } ctx_t;

  // One word of the twist from the current, next and far init words.
  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & HighBit) | (nxt & LowBits);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TwistXor;
    end
    return v;
  endfunction

  // Output tempering of one twisted word.
  function automatic logic [31:0] temper_word(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

### rtl/core/mt19937_seed_offset_check_top.sv
`timescale 1ns / 1ps
`default_nettype none
// From the accepting edge to out_valid_o an item passes the input register,
//   400 init stages, twist, temper, 32 remainder stages and the output register.
// Throughput: one item per cycle unless the output stalls; each init stage holds one 32x32 multiply.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// mt19937_seed_offset_check_top: MT19937 seed offset check.
// Builds the init words, twists and tempers four outputs, reduces them by
// the offset range and compares against the targets.
// ----------------------------------------------------------------------------
module mt19937_seed_offset_check_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] seed_value_i,
  input  wire logic [15:0] target_x_i,
  input  wire logic [15:0] target_z_i,
  input  wire logic [15:0] modulus_i,
  input  wire logic        spread_mode_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             match_o
);
  import mtsoc_pkg::*;

  logic                  en;
  logic                  vld_q  [InitLen+1];
  logic [31:0]           w_q    [InitLen+1];
  ctx_t                  ctx_q  [InitLen+1];
  logic                  tw_vld_q;
  logic [3:0][31:0]      tw_q;
  side_t                 tw_side_q;
  logic                  tp_vld_q;
  logic [3:0][31:0]      tp_q;
  side_t                 tp_side_q;
  logic                  rem_vld;
  logic [3:0][31:0]      rem;
  side_t                 rem_side;
  logic                  out_valid_q;
  logic                  match_q;
  logic                  match_d;

  // The pipeline advances whenever the output register can take an item.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Input register: the seed is init word zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q[0]                 <= seed_value_i;
      ctx_q[0].lo            <= {{((LoWords-1)*32){1'b0}}, seed_value_i};
      ctx_q[0].hi            <= '0;
      ctx_q[0].side.tx       <= target_x_i;
      ctx_q[0].side.tz       <= target_z_i;
      ctx_q[0].side.m        <= modulus_i;
      ctx_q[0].side.tri_mode <= spread_mode_i;
    end
  end

  // Init chain: one recurrence step per stage, keeping the words we need.
  for (genvar i = 1; i <= InitLen; i++) begin : g_init
    logic [31:0] w_d;
    ctx_t        ctx_d;

    assign w_d = 32'(InitMult * (w_q[i-1] ^ (w_q[i-1] >> 30))) + 32'(i);

    if (i < LoWords) begin : g_lo
      always_comb begin
        ctx_d       = ctx_q[i-1];
        ctx_d.lo[i] = w_d;
      end
    end else if (i >= ShiftM) begin : g_hi
      always_comb begin
        ctx_d              = ctx_q[i-1];
        ctx_d.hi[i-ShiftM] = w_d;
      end
    end else begin : g_pass
      assign ctx_d = ctx_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        w_q[i]   <= w_d;
        ctx_q[i] <= ctx_d;
      end
    end
  end

  // Twist and temper stages, one register each.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_vld_q <= 1'b0;
      tp_vld_q <= 1'b0;
    end else if (en) begin
      tw_vld_q <= vld_q[InitLen];
      tp_vld_q <= tw_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        tw_q[k] <= twist_word(ctx_q[InitLen].lo[k], ctx_q[InitLen].lo[k+1],
                              ctx_q[InitLen].hi[k]);
        tp_q[k] <= temper_word(tw_q[k]);
      end
      tw_side_q <= ctx_q[InitLen].side;
      tp_side_q <= tw_side_q;
    end
  end

  // Reduction by the offset range.
  mtsoc_rem_pipe u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (tp_vld_q),
    .dividend_i (tp_q),
    .side_i     (tp_side_q),
    .vld_o      (rem_vld),
    .rem_o      (rem),
    .side_o     (rem_side)
  );

  // Final compare, linear or averaged pairs.
  always_comb begin
    logic [32:0] sx;
    logic [32:0] sz;
    sx = {1'b0, rem[0]} + {1'b0, rem[1]};
    sz = {1'b0, rem[2]} + {1'b0, rem[3]};
    if (rem_side.tri_mode) begin
      match_d = (sx[32:1] == {16'h0, rem_side.tx}) &&
                (sz[32:1] == {16'h0, rem_side.tz});
    end else begin
      match_d = (rem[0] == {16'h0, rem_side.tx}) &&
                (rem[1] == {16'h0, rem_side.tz});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rem_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      match_q <= match_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign match_o     = match_q;

  // An accepted item lands in the input register.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted item missing from input register");

  // The pipeline only stalls behind a waiting result.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("stall without a pending result");

  // A stalled pipeline keeps the valid bits of the last init stage and the temper stage unchanged.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q[InitLen]) && $stable(tp_vld_q))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

### rtl/core/mtsoc_rem_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsoc_rem_pipe: pipelined remainder of four words by the offset range.
// Restoring division, one dividend bit per stage for all four words, with
// a zero range giving the dividend itself.
// ----------------------------------------------------------------------------
module mtsoc_rem_pipe (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   vld_i,
  input  wire logic [3:0][31:0]       dividend_i,
  input  wire mtsoc_pkg::side_t       side_i,
  output logic                        vld_o,
  output logic [3:0][31:0]            rem_o,
  output mtsoc_pkg::side_t            side_o
);
  import mtsoc_pkg::*;

  logic                 vld_q   [RemSteps];
  logic [3:0][31:0]     a_q     [RemSteps];
  logic [3:0][15:0]     r_q     [RemSteps];
  side_t                side_q  [RemSteps];

  for (genvar j = 0; j < RemSteps; j++) begin : g_step
    logic             vld_p;
    logic [3:0][31:0] a_p;
    logic [3:0][15:0] r_p;
    side_t            side_p;
    logic [3:0][15:0] r_d;

    // Stage input comes from the ports for the first step.
    if (j == 0) begin : g_first
      assign vld_p  = vld_i;
      assign a_p    = dividend_i;
      assign r_p    = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[j-1];
      assign a_p    = a_q[j-1];
      assign r_p    = r_q[j-1];
      assign side_p = side_q[j-1];
    end

    // Shift in one dividend bit and subtract the range when it fits.
    always_comb begin
      logic [16:0] rs;
      for (int k = 0; k < 4; k++) begin
        rs = {r_p[k], a_p[k][RemSteps-1-j]};
        if (rs >= {1'b0, side_p.m}) begin
          rs = rs - {1'b0, side_p.m};
        end
        r_d[k] = rs[15:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[j]    <= a_p;
        r_q[j]    <= r_d;
        side_q[j] <= side_p;
      end
    end
  end

  // A zero range passes the whole word on.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem_o[k] = (side_q[RemSteps-1].m == '0) ? a_q[RemSteps-1][k]
                                               : {16'h0, r_q[RemSteps-1][k]};
    end
  end

  assign vld_o  = vld_q[RemSteps-1];
  assign side_o = side_q[RemSteps-1];

  // A held pipeline keeps its last valid bit.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_o))
    else $error("remainder pipeline moved while held");

  // An item entering with the pipeline running shows up in the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && vld_i) |=> vld_q[0])
    else $error("remainder pipeline lost an item");

  // A bubble entering with the pipeline running stays a bubble.
  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !vld_i) |=> !vld_q[0])
    else $error("remainder pipeline made up an item");

endmodule
`default_nettype wire
